// ----- hdl/bsr_pkg.sv -----
// Shared types, constants and helpers for the byte stream reassembler.
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

	// Reorder window depth in cells; counts are 7 bits wide to hold the full depth.
	localparam int CAP   = 64;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = 7;
	localparam int POS_W = 33;

	// Contiguous-run scan looks at one group of cells per cycle.
	localparam int GRP   = 8;
	localparam int NGRP  = CAP / GRP;
	localparam int GRP_W = $clog2(NGRP);
	localparam int LO_W  = $clog2(GRP + 1);

	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_END     = 2'd1;
	localparam logic [1:0] ACT_CONSUME = 2'd2;
	localparam logic [1:0] ACT_IDLE    = 2'd3;

	localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic [31:0] stream_index;
		logic        is_eof;
		logic [6:0]  consume_count;
	} seg_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       stream_ended;
		logic [6:0] unassembled_count;
		logic       last;
	} res_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRUNE,
		ST_SCAN,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic shift;
		logic clr;
		logic wr;
	} cell_ctl_t;

	typedef struct packed {
		logic             shift;
		logic             clr;
		logic             wr;
		logic [IDX_W-1:0] sel;
		logic [7:0]       data;
	} chain_ctl_t;

	// Count of consecutive set bits starting at bit 0.
	function automatic logic [LO_W-1:0] lead_ones(input logic [GRP-1:0] v);
		logic [LO_W-1:0] c;
		logic            run;
		c   = '0;
		run = 1'b1;
		for (int i = 0; i < GRP; i++) begin
			run = run & v[i];
			c   = c + LO_W'(run);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bsr_cell.sv -----
// One reorder window cell: a valid flag and a byte, shifting toward the window front.
`timescale 1ns / 1ps
`default_nettype none

module bsr_cell
	import bsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire logic [7:0] wdata,
	input  wire logic       nbr_vld,
	input  wire logic [7:0] nbr_val,
	output logic            vld,
	output logic [7:0]      val
);

	logic       vld_q;
	logic [7:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= nbr_vld;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.wr) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= nbr_val;
		end else if (ctl.wr) begin
			val_q <= wdata;
		end
	end

	assign vld = vld_q;
	assign val = val_q;

endmodule

`default_nettype wire

// ----- hdl/bsr_chain.sv -----
// Row of window cells with per-cell select decode; cell 0 is the next expected byte.
`timescale 1ns / 1ps
`default_nettype none

module bsr_chain
	import bsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire chain_ctl_t ctl,
	output logic [CAP-1:0]  vld,
	output logic [7:0]      head_val
);

	logic [7:0] val_w [CAP];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		cell_ctl_t  cctl;
		logic       nv;
		logic [7:0] nval;

		assign cctl.shift = ctl.shift;
		assign cctl.clr   = ctl.clr && (ctl.sel == IDX_W'(i));
		assign cctl.wr    = ctl.wr && (ctl.sel == IDX_W'(i));

		if (i == CAP - 1) begin : g_tail
			assign nv   = 1'b0;
			assign nval = 8'h00;
		end else begin : g_body
			assign nv   = vld[i+1];
			assign nval = val_w[i+1];
		end

		bsr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cctl),
			.wdata   (ctl.data),
			.nbr_vld (nv),
			.nbr_val (nval),
			.vld     (vld[i]),
			.val     (val_w[i])
		);
	end

	assign head_val = val_w[0];

endmodule

`default_nettype wire

// ----- hdl/byte_stream_reassembler.sv -----
// Byte stream reassembler top level: sequencer, window bookkeeping and result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  seg      | in        | seg_valid / seg_stall| seg_data   (seg_beat_t)
//  res      | out       | res_valid / res_stall| res_data   (res_beat_t)
//  cfg      | in        | cfg_we               | cfg_wdata  (window capacity)
//
//  Each beat passes through accept, prune and insert, scan, finish and emit, in
//  that order. Prune drops the cells above a window that shrank (usually none);
//  scan runs for a byte beat only and walks the cell groups until the contiguous
//  run ends; emit delivers the N bytes of that run, or one empty result if N is 0.
//  The emit phase delivers one byte per cycle as the cell row shifts by one.
//  Reset clears the valid flags, counters and end tracking at once; no sweep.
//  A stalled result holds the emit phase; a new beat is taken once the last
//  result of the previous beat sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_reassembler
	import bsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       seg_valid,
	output logic            seg_stall,
	input  wire seg_beat_t  seg_data,
	output logic            res_valid,
	input  wire logic       res_stall,
	output res_beat_t       res_data,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);

	// Sequencer and window bookkeeping
	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cap_q;
	logic [POS_W-1:0]  ne_q;        // next expected stream position
	logic [CNT_W-1:0]  held_q;      // bytes in the window not yet delivered
	logic [CNT_W-1:0]  buf_q;       // bytes delivered but not yet consumed
	logic              end_seen_q;
	logic [POS_W-1:0]  end_pos_q;
	logic              ended_q;
	logic [CNT_W-1:0]  lim_q;       // no valid cell at or above this index
	logic [CNT_W-1:0]  wsize_q;     // window size sampled at accept
	logic [GRP_W-1:0]  grp_q;
	logic [CNT_W-1:0]  n_q;         // run length to deliver
	logic [CNT_W-1:0]  emit_q;      // bytes still to deliver

	// Latched beat
	logic [1:0]        act_q;
	logic [7:0]        dat_q;
	logic [31:0]       idx_q;
	logic              eof_q;
	logic [6:0]        cons_q;

	// Output register
	logic              res_valid_q;
	res_beat_t         res_q;

	// Cell row
	chain_ctl_t        cctl;
	logic [CAP-1:0]    vld;
	logic [7:0]        head_val;

	bsr_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cctl),
		.vld      (vld),
		.head_val (head_val)
	);

	// Window size: room left downstream under the effective capacity.
	logic [CNT_W-1:0] eff_cap;
	logic [CNT_W-1:0] wsize_now;

	assign eff_cap   = (cap_q > CNT_W'(CAP)) ? CNT_W'(CAP) : cap_q;
	assign wsize_now = (buf_q >= eff_cap) ? '0 : eff_cap - buf_q;

	// Prune: drop cells beyond a window that shrank, one per cycle from the top.
	logic             prune_go;
	logic [IDX_W-1:0] prune_sel;

	assign prune_go  = lim_q > wsize_q;
	assign prune_sel = IDX_W'(lim_q - CNT_W'(1));

	// Insert decision for a segment byte.
	logic [POS_W-1:0] pos_idx;
	logic [POS_W-1:0] end_pos_eof;
	logic [POS_W-1:0] rel;
	logic             in_win;
	logic             past_end;
	logic             ins_new;
	logic [IDX_W-1:0] slot;

	assign pos_idx     = {1'b0, idx_q};
	assign end_pos_eof = pos_idx + POS_W'(1);
	assign rel         = pos_idx - ne_q;
	assign in_win      = (pos_idx >= ne_q) && (rel < POS_W'(wsize_q));
	// An end byte never lies at or beyond its own end position.
	assign past_end    = !eof_q && end_seen_q && (pos_idx >= end_pos_q);
	assign slot        = rel[IDX_W-1:0];
	assign ins_new     = (act_q == ACT_BYTE) && !ended_q && !past_end && in_win && !vld[slot];

	// Run scan: one group of cells per cycle.
	logic [IDX_W-1:0] grp_base;
	logic [LO_W-1:0]  grp_lo;
	logic             scan_done;
	logic [CNT_W-1:0] n_scan;

	assign grp_base  = {grp_q, (IDX_W-GRP_W)'(0)};
	assign grp_lo    = lead_ones(vld[grp_base +: GRP]);
	assign scan_done = (grp_lo != LO_W'(GRP)) || (grp_q == GRP_W'(NGRP - 1));
	assign n_scan    = CNT_W'(grp_base) + CNT_W'(grp_lo);

	// Finish: close the stream once everything before the end is delivered.
	logic [POS_W-1:0] ne_fin;
	logic             ended_fin;

	assign ne_fin    = ne_q + POS_W'(n_q);
	assign ended_fin = ended_q || (end_seen_q && (ne_fin >= end_pos_q));

	// Emit: load the output register whenever it is free or being drained.
	logic      load_res;
	res_beat_t res_d;

	assign load_res = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		res_d.out_byte          = (emit_q != '0) ? head_val : 8'h00;
		res_d.byte_valid        = emit_q != '0;
		res_d.stream_ended      = ended_q;
		res_d.unassembled_count = held_q;
		res_d.last              = emit_q <= CNT_W'(1);
	end

	// Next state and cell row control
	always_comb begin
		state_d    = state_q;
		seg_stall  = 1'b1;
		cctl       = '0;
		cctl.data  = dat_q;
		unique case (state_q)
			ST_IDLE: begin
				seg_stall = 1'b0;
				if (seg_valid) state_d = ST_PRUNE;
			end
			ST_PRUNE: begin
				if (prune_go) begin
					cctl.clr = 1'b1;
					cctl.sel = prune_sel;
				end else begin
					cctl.wr  = ins_new;
					cctl.sel = slot;
					state_d  = (act_q == ACT_BYTE) ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cctl.shift = load_res && (emit_q != '0);
				if (load_res && res_d.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CFG_RESET;
			ne_q        <= '0;
			held_q      <= '0;
			buf_q       <= '0;
			end_seen_q  <= 1'b0;
			end_pos_q   <= '0;
			ended_q     <= 1'b0;
			lim_q       <= '0;
			wsize_q     <= '0;
			grp_q       <= '0;
			n_q         <= '0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;

			unique case (state_q)
				ST_IDLE: begin
					if (seg_valid) wsize_q <= wsize_now;
				end
				ST_PRUNE: begin
					if (prune_go) begin
						lim_q <= lim_q - CNT_W'(1);
						if (vld[prune_sel]) held_q <= held_q - CNT_W'(1);
					end else begin
						// Every valid cell now lies inside the sampled window.
						lim_q <= wsize_q;
						grp_q <= '0;
						n_q   <= '0;
						unique case (act_q)
							ACT_BYTE: begin
								if (eof_q) begin
									end_seen_q <= 1'b1;
									end_pos_q  <= end_pos_eof;
								end
								if (ins_new) held_q <= held_q + CNT_W'(1);
							end
							ACT_END: begin
								end_seen_q <= 1'b1;
								end_pos_q  <= pos_idx;
							end
							ACT_CONSUME: begin
								// Saturate at zero on over consumption.
								buf_q <= (CNT_W'(cons_q) >= buf_q) ? '0
									: buf_q - CNT_W'(cons_q);
							end
							ACT_IDLE: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						n_q <= n_scan;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				ST_FIN: begin
					// Commit the delivery now; the row catches up during emit.
					ne_q    <= ne_fin;
					ended_q <= ended_fin;
					buf_q   <= buf_q + n_q;
					held_q  <= held_q - n_q;
					lim_q   <= lim_q - n_q;
					emit_q  <= n_q;
				end
				ST_EMIT: begin
					if (load_res && (emit_q != '0)) emit_q <= emit_q - CNT_W'(1);
				end
				default: begin
				end
			endcase

			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Beat payload and result payload: no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && seg_valid) begin
			act_q  <= seg_data.action;
			dat_q  <= seg_data.data_byte;
			idx_q  <= seg_data.stream_index;
			eof_q  <= seg_data.is_eof;
			cons_q <= seg_data.consume_count;
		end
		if (load_res) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Held bytes always fit below the occupancy bound.
	a_held_le_lim: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= lim_q)
		else $error("held count above occupancy bound");

	// A byte being delivered must sit valid at the window front.
	a_emit_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && (emit_q != '0) |-> vld[0])
		else $error("delivering from an empty front cell");

	// The downstream buffer never exceeds the window depth.
	a_buf_cap: assert property (@(posedge clk) disable iff (!arst_n)
		buf_q <= CNT_W'(CAP))
		else $error("buffered count above capacity");

	// Loading the final result of a beat returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_res && res_d.last |=> state_q == ST_IDLE)
		else $error("sequencer not idle after final result");

	// A result without a byte is always the only, and final, one.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.byte_valid |-> res_data.last)
		else $error("empty result not marked last");

endmodule

`default_nettype wire

// ----- sim/byte_stream_reassembler_tb.sv -----
// Self-checking testbench for the byte stream reassembler: directed and random beats.
`timescale 1ns / 1ps

module byte_stream_reassembler_tb;
	import bsr_pkg::*;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            seg_valid = 1'b0;
	logic            seg_stall;
	seg_beat_t       seg_data  = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	res_beat_t       res_data;
	logic            cfg_we    = 1'b0;
	logic [6:0]      cfg_wdata = '0;

	byte_stream_reassembler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg_data  (seg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Beats waiting for the segment channel, and result beats the block still owes.
	seg_beat_t seg_backlog   [$];
	res_beat_t owed_results  [$];

	// Idle rates in percent for each side; changed only while the block is drained.
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;

	int  mismatch_count  = 0;
	int  results_checked = 0;
	int  beats_queued    = 0;
	int  settings_used   = 0;
	int  longest_run     = 0;
	logic seg_fire       = 1'b0;

	// Shadow of the reassembler state: reorder window, counters and end tracking.
	logic [7:0]       win_data [CAP];
	bit               win_full [CAP];
	logic [POS_W-1:0] next_pos     = '0;
	logic [CNT_W-1:0] held         = '0;
	logic [CNT_W-1:0] buffered     = '0;
	logic             end_known    = 1'b0;
	logic [POS_W-1:0] end_pos      = '0;
	logic             closed       = 1'b0;
	logic [CNT_W-1:0] capacity_reg = CFG_RESET;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Room left for reordering: capacity (clamped to the window depth) minus
	// bytes delivered but not yet consumed by the reader.
	function automatic logic [CNT_W-1:0] window_room();
		logic [CNT_W-1:0] eff;
		eff = (capacity_reg > CNT_W'(CAP)) ? CNT_W'(CAP) : capacity_reg;
		return (buffered >= eff) ? '0 : eff - buffered;
	endfunction

	// Advance the shadow state by one segment beat and queue the result beats it owes.
	function automatic void reassemble_beat(input seg_beat_t b);
		logic [CNT_W-1:0] room;
		logic [POS_W:0]   lim;
		logic [IDX_W-1:0] s;
		logic [7:0]       run [$];
		res_beat_t        r;
		int               off;
		room = window_room();
		// Drop held bytes that a shrunk window no longer covers.
		for (off = int'(room); off < CAP; off++) begin
			s = next_pos[IDX_W-1:0] + IDX_W'(off);
			if (win_full[s]) begin
				win_full[s] = 1'b0;
				if (held != 0)
					held--;
			end
		end
		case (b.action)
			ACT_BYTE: begin
				if (b.is_eof) begin
					end_known = 1'b1;
					end_pos   = {1'b0, b.stream_index} + 1'b1;
				end
				lim = (POS_W+1)'(next_pos) + (POS_W+1)'(room);
				// First copy of a position wins; bytes past the end or outside the window drop.
				if (!closed && !(end_known && {1'b0, b.stream_index} >= end_pos) &&
				    {1'b0, b.stream_index} >= next_pos &&
				    (POS_W+1)'(b.stream_index) < lim) begin
					s = b.stream_index[IDX_W-1:0];
					if (!win_full[s]) begin
						win_data[s] = b.data_byte;
						win_full[s] = 1'b1;
						held++;
					end
				end
				// Deliver the contiguous run at the window front.
				while (run.size() < CAP && held != 0 && win_full[next_pos[IDX_W-1:0]]) begin
					s = next_pos[IDX_W-1:0];
					run.insert(run.size(), win_data[s]);
					win_full[s] = 1'b0;
					held--;
					next_pos++;
					buffered++;
				end
			end
			ACT_END: begin
				end_known = 1'b1;
				end_pos   = {1'b0, b.stream_index};
			end
			ACT_CONSUME: begin
				buffered = (b.consume_count >= buffered) ? '0 : buffered - b.consume_count;
			end
			default: ;
		endcase
		if (end_known && next_pos >= end_pos)
			closed = 1'b1;
		if (run.size() > longest_run)
			longest_run = run.size();
		r.stream_ended      = closed;
		r.unassembled_count = held;
		if (run.size() == 0) begin
			r.out_byte   = '0;
			r.byte_valid = 1'b0;
			r.last       = 1'b1;
			owed_results.insert(owed_results.size(), r);
		end else begin
			foreach (run[k]) begin
				r.out_byte   = run[k];
				r.byte_valid = 1'b1;
				r.last       = (k == run.size() - 1);
				owed_results.insert(owed_results.size(), r);
			end
		end
	endfunction

	task automatic push_beat(input seg_beat_t b);
		reassemble_beat(b);
		seg_backlog.insert(seg_backlog.size(), b);
		beats_queued++;
	endtask

	// Fields a beat's action ignores get random values so every bit toggles.
	task automatic put_byte(input logic [31:0] idx, input logic [7:0] data, input logic eof);
		seg_beat_t b;
		b.action        = ACT_BYTE;
		b.data_byte     = data;
		b.stream_index  = idx;
		b.is_eof        = eof;
		b.consume_count = 7'($urandom_range(64));
		push_beat(b);
	endtask

	task automatic put_end(input logic [31:0] idx);
		seg_beat_t b;
		b.action        = ACT_END;
		b.data_byte     = 8'($urandom);
		b.stream_index  = idx;
		b.is_eof        = 1'($urandom);
		b.consume_count = 7'($urandom_range(64));
		push_beat(b);
	endtask

	task automatic put_consume(input logic [6:0] n);
		seg_beat_t b;
		b.action        = ACT_CONSUME;
		b.data_byte     = 8'($urandom);
		b.stream_index  = $urandom;
		b.is_eof        = 1'($urandom);
		b.consume_count = n;
		push_beat(b);
	endtask

	task automatic put_idle();
		seg_beat_t b;
		b.action        = ACT_IDLE;
		b.data_byte     = 8'($urandom);
		b.stream_index  = $urandom;
		b.is_eof        = 1'($urandom);
		b.consume_count = 7'($urandom_range(64));
		push_beat(b);
	endtask

	// Hold off the sender until every owed result has arrived, then write the
	// capacity register and switch the idle rates.
	task automatic reconfigure(input logic [6:0] cap, input int send_pct, input int recv_pct);
		while (seg_backlog.size() != 0 || owed_results.size() != 0)
			@(posedge clk);
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we    <= 1'b0;
		capacity_reg = cap;
		settings_used++;
		@(posedge clk);
	endtask

	// Deliver a few bytes in order, then park some ahead of the front so the
	// next, smaller window has held bytes to discard and an overfull buffer.
	task automatic prepare_shrink();
		logic [POS_W-1:0] base;
		base = next_pos;
		put_byte(base[31:0], 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd1, 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd2, 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd4, 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd7, 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd12, 8'($urandom), 1'b0);
	endtask

	// Mostly shuffled segments near the window front, with reader consumption,
	// at most one full-window burst delivered by its last byte, and some noise.
	task automatic random_traffic(input int beats);
		int               issued, pick, len, i, j, t;
		bit               burst_done;
		logic [POS_W-1:0] base;
		int               order [$];
		issued     = 0;
		burst_done = 1'b0;
		while (issued < beats) begin
			pick = $urandom_range(99);
			if (window_room() == 0 || pick < 15) begin
				put_consume(7'($urandom_range(64)));
				issued++;
			end else if (pick < 20 && !burst_done) begin
				// Fill the whole window back to front; the front byte flushes it all.
				put_consume(7'd64);
				base = next_pos;
				len  = int'(window_room());
				for (i = len - 1; i >= 0; i--)
					put_byte(base[31:0] + 32'(i), 8'($urandom), 1'b0);
				burst_done = 1'b1;
				issued += len + 1;
			end else if (pick < 88) begin
				len = $urandom_range(1, 8);
				if (pick % 7 == 0 && next_pos >= 2)
					base = next_pos - 2;
				else if (pick < 55)
					base = next_pos;
				else
					base = next_pos + POS_W'($urandom_range(int'(window_room()) + 1));
				order.delete();
				for (i = 0; i < len; i++)
					order.insert(order.size(), i);
				for (i = len - 1; i > 0; i--) begin
					j        = $urandom_range(i);
					t        = order[i];
					order[i] = order[j];
					order[j] = t;
				end
				foreach (order[k]) begin
					put_byte(base[31:0] + 32'(order[k]), 8'($urandom), 1'b0);
					if ($urandom_range(7) == 0) begin
						put_byte(base[31:0] + 32'(order[k]), 8'($urandom), 1'b0);
						issued++;
					end
				end
				issued += len;
			end else begin
				// Noise: stray positions, far end markers and far end bytes.
				case ($urandom_range(3))
					0: put_byte($urandom, 8'($urandom), 1'b0);
					1: put_end({1'b1, 31'($urandom)});
					2: put_byte({1'b1, 31'($urandom)}, 8'($urandom), 1'b1);
					default: put_byte(32'(next_pos + POS_W'(window_room())), 8'($urandom), 1'b0);
				endcase
				issued++;
			end
		end
	endtask

	// Note each accepted segment beat; the driver retires it at the next falling edge.
	always @(posedge clk)
		seg_fire <= seg_valid && !seg_stall;

	// Driver: hold a stalled beat, otherwise present the next one unless idling.
	always @(negedge clk) begin
		if (seg_fire)
			seg_backlog.delete(0);
		if (seg_valid && !seg_fire) begin
			// hold the stalled beat as it is
		end else if (seg_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
			seg_valid <= 1'b1;
			seg_data  <= seg_backlog[0];
		end else begin
			seg_valid <= 1'b0;
		end
		res_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Monitor: compare every accepted result beat with the oldest owed one.
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (owed_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result beat %p", $time, res_data);
			end else begin
				want = owed_results[0];
				owed_results.delete(0);
				results_checked++;
				if (res_data.out_byte !== want.out_byte ||
				    res_data.byte_valid !== want.byte_valid ||
				    res_data.stream_ended !== want.stream_ended ||
				    res_data.unassembled_count !== want.unassembled_count ||
				    res_data.last !== want.last) begin
					mismatch_count++;
					$display("%0t: result mismatch, expected %p, actual %p",
					         $time, want, res_data);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("byte_stream_reassembler_tb: FAIL");
		$finish;
	end

	initial begin
		logic [POS_W-1:0] base;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily.
		reconfigure(7'd64, 23, 70);

		// In order, out of order, duplicate positions and data extremes.
		put_byte(32'd0, 8'h00, 1'b0);
		put_byte(32'd2, 8'hFF, 1'b0);
		put_byte(32'd1, 8'hA5, 1'b0);
		put_byte(32'd5, 8'h11, 1'b0);
		put_byte(32'd5, 8'h22, 1'b0);
		put_byte(32'd4, 8'h5A, 1'b0);
		put_byte(32'd3, 8'hC3, 1'b0);
		// Already delivered, far away, and just outside / inside the window edge.
		put_byte(32'd0, 8'h77, 1'b0);
		put_byte(32'hFFFF_FFFF, 8'h01, 1'b0);
		put_byte(32'd64, 8'h66, 1'b0);
		put_byte(32'd63, 8'h80, 1'b0);
		// Reader takes more than was delivered; the window reopens to full size.
		put_consume(7'd64);
		put_byte(32'd69, 8'h3C, 1'b0);
		put_byte(32'd70, 8'hC7, 1'b0);
		// End markers replace one another; bytes at or past the end drop.
		put_end(32'hFFFF_FFFF);
		put_byte(32'hFFFF_FFFF, 8'hE7, 1'b1);
		put_end(32'd10);
		put_byte(32'd11, 8'h5F, 1'b0);
		put_byte(32'd10, 8'hF5, 1'b0);
		put_byte(32'd7, 8'h99, 1'b0);
		put_end(32'hFFFF_FF00);
		put_consume(7'd0);
		put_idle();
		put_byte(32'd6, 8'h42, 1'b0);
		put_consume(7'd3);

		random_traffic(80);
		prepare_shrink();
		// Receiver idles lightly, sender heavily; smallest window first.
		reconfigure(7'd1, 70, 23);
		random_traffic(20);
		reconfigure(7'd40, 70, 23);
		random_traffic(60);
		prepare_shrink();
		// Neither side idles from here on.
		reconfigure(7'd23, 0, 0);
		random_traffic(60);
		reconfigure(7'd64, 0, 0);
		random_traffic(60);

		// Close the stream: a held byte beyond the end, a byte past the end,
		// then the front bytes that complete it; everything after drops.
		put_consume(7'd64);
		base = next_pos;
		put_byte(base[31:0] + 32'd5, 8'($urandom), 1'b0);
		put_end(base[31:0] + 32'd2);
		put_byte(base[31:0] + 32'd3, 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd1, 8'($urandom), 1'b0);
		put_byte(base[31:0], 8'($urandom), 1'b0);
		put_byte(base[31:0] + 32'd2, 8'($urandom), 1'b0);
		put_end(32'd0);
		put_byte(base[31:0] + 32'd6, 8'($urandom), 1'b1);

		while (seg_backlog.size() != 0 || owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d segment beats across %0d capacity settings; checked %0d result beats.",
		         beats_queued, settings_used, results_checked);
		$display("Longest delivery from one beat: %0d bytes; stream closed: %0b.",
		         longest_run, closed);
		if (mismatch_count == 0)
			$display("byte_stream_reassembler_tb: PASS");
		else
			$display("byte_stream_reassembler_tb: FAIL");
		$finish;
	end

endmodule
